/* design/gsbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbm_pkg
// Shared types and constants of the gas sensor baseline monitor.
// ----------------------------------------------------------------------------
package gsbm_pkg;

	typedef enum logic [1:0] {
		PH_WARMUP = 2'd0,
		PH_CALIB  = 2'd1,
		PH_READY  = 2'd2,
		PH_FAULT  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		LVL_OK   = 2'd0,
		LVL_HIGH = 2'd1,
		LVL_CRIT = 2'd2
	} level_t;

	typedef enum logic [2:0] {
		CFG_WARMUP   = 3'd0,
		CFG_CALIB    = 3'd1,
		CFG_SIG_A    = 3'd2,
		CFG_BASE_A   = 3'd3,
		CFG_HIGH_PCT = 3'd4,
		CFG_CRIT_PCT = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MED,
		ST_SEMA,
		ST_BEMA,
		ST_DIV,
		ST_OUT
	} state_t;

	localparam int FRAC_BITS = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam logic [15:0] DEV_SAT = 16'hFFFF;

	// control between sequencer and serial units
	typedef struct packed {
		logic start;
		logic busy;
	} unit_ctl_t;

endpackage

/* design/gsbm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbm_in_if / gsbm_out_if / gsbm_cfg_if
// Valid/ready channels of the monitor.
// ----------------------------------------------------------------------------
interface gsbm_in_if #(parameter int SAMPLE_BITS = 12);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic [31:0]            now_ms;
	logic                   restart;
	modport source (output valid, sample, now_ms, restart, input ready);
	modport sink (input valid, sample, now_ms, restart, output ready);
endinterface

interface gsbm_out_if #(parameter int SAMPLE_BITS = 12);
	logic                   valid;
	logic                   ready;
	logic [1:0]             phase;
	logic [15:0]            deviation_pct;
	logic [1:0]             level;
	logic [SAMPLE_BITS-1:0] filtered_value;
	modport source (output valid, phase, deviation_pct, level, filtered_value, input ready);
	modport sink (input valid, phase, deviation_pct, level, filtered_value, output ready);
endinterface

interface gsbm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/gsbm_ser_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbm_ser_mul
// Bit-serial unsigned multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module gsbm_ser_mul #(
	parameter int AW = 28,
	parameter int BW = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [AW-1:0]     a,
	input  logic [BW-1:0]     b,
	output logic              busy,
	output logic [AW+BW-1:0]  prod
);
	localparam int CW = $clog2(BW + 1);

	logic [AW+BW-1:0] acc_q;
	logic [AW+BW-1:0] mcand_q;
	logic [BW-1:0]    mplier_q;
	logic [CW-1:0]    cnt_q;

	// control counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(BW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift and add, one bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= {{BW{1'b0}}, a};
			mplier_q <= b;
		end else if (cnt_q != '0) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign busy = (cnt_q != '0);
	assign prod = acc_q;
endmodule

/* design/gsbm_ser_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbm_ser_div
// Restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gsbm_ser_div #(
	parameter int NW = 36,
	parameter int DW = 28
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [DW:0]   rem_q;
	logic [NW-1:0] q_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift in next numerator bit, trial subtract
	assign trial = {rem_q[DW-1:0], q_q[NW-1]};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= num;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, den}) begin
				rem_q <= trial - {1'b0, den};
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = q_q;
endmodule

/* design/gsbm_median.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsbm_median
// Sample window with a rank-count median, one window entry per cycle.
// ----------------------------------------------------------------------------
module gsbm_median #(
	parameter int MEDIAN_LEN  = 5,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gsbm_pkg::unit_ctl_t    ctl_in,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   busy,
	output logic [SAMPLE_BITS-1:0] median
);
	localparam int PW = $clog2(MEDIAN_LEN);
	localparam int FW = $clog2(MEDIAN_LEN + 1);

	logic [SAMPLE_BITS-1:0] win_q [MEDIAN_LEN];
	logic [PW-1:0]          pos_q;
	logic [FW-1:0]          fill_q;
	logic [PW-1:0]          cand_q;
	logic [PW-1:0]          scan_q;
	logic [FW-1:0]          lt_q;
	logic [FW-1:0]          le_q;
	logic                   run_q;
	logic [SAMPLE_BITS-1:0] med_q;
	logic [FW-1:0]          target;
	logic [SAMPLE_BITS-1:0] cval;
	logic [SAMPLE_BITS-1:0] sval;
	logic [FW-1:0]          lt_n;
	logic [FW-1:0]          le_n;
	logic                   last_scan;

	assign target    = fill_q >> 1;
	assign cval      = win_q[cand_q];
	assign sval      = win_q[scan_q];
	assign lt_n      = lt_q + FW'(sval < cval);
	assign le_n      = le_q + FW'(sval <= cval);
	assign last_scan = (FW'(scan_q) == fill_q - 1'b1);

	// window write on start
	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			win_q[pos_q] <= sample;
		end
	end

	// candidate element is the median when its rank range covers fill/2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
			run_q  <= 1'b0;
			cand_q <= '0;
			scan_q <= '0;
			lt_q   <= '0;
			le_q   <= '0;
		end else if (ctl_in.start) begin
			pos_q  <= (pos_q == PW'(MEDIAN_LEN - 1)) ? '0 : pos_q + 1'b1;
			if (fill_q != FW'(MEDIAN_LEN)) begin
				fill_q <= fill_q + 1'b1;
			end
			run_q  <= 1'b1;
			cand_q <= '0;
			scan_q <= '0;
			lt_q   <= '0;
			le_q   <= '0;
		end else if (run_q) begin
			if (last_scan) begin
				scan_q <= '0;
				lt_q   <= '0;
				le_q   <= '0;
				if (lt_n <= target && target < le_n) begin
					run_q <= 1'b0;
				end else begin
					cand_q <= cand_q + 1'b1;
				end
			end else begin
				scan_q <= scan_q + 1'b1;
				lt_q   <= lt_n;
				le_q   <= le_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q && last_scan) begin
			med_q <= cval;
		end
	end

	assign busy   = run_q;
	assign median = med_q;
endmodule

/* design/gas_sensor_baseline_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_sensor_baseline_monitor
// Median, signal EMA, adaptive baseline EMA and percent deviation grading.
// ----------------------------------------------------------------------------
// One item is taken at a time. A fault sample goes from idle straight to the
// output state and then to the result register. A good sample passes the
// rank-count median, then a bit-serial EMA multiply for each product (17 bit
// steps plus start and capture, two multiplies per EMA), and in the ready
// phase the restoring divider. The serial median, multiplier and divider set
// how long an item takes.
// A new item is taken once the previous result item has been taken, or in
// the cycle where it is taken.
module gas_sensor_baseline_monitor #(
	parameter int MEDIAN_LEN  = 5,
	parameter int SAMPLE_BITS = 12
) (
	input logic     clk,
	input logic     arst_n,
	gsbm_in_if.sink   in_ch,
	gsbm_out_if.source out_ch,
	gsbm_cfg_if.sink  cfg
);
	localparam int AVW = SAMPLE_BITS + gsbm_pkg::FRAC_BITS;
	localparam int AW  = 17;
	localparam int PW  = AVW + AW;
	localparam int NW  = AVW + 7;

	// configuration registers
	logic [31:0] warmup_q, calib_q;
	logic [15:0] sig_a_q, base_a_q, high_q, crit_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q <= '0;
			calib_q  <= '0;
			sig_a_q  <= 16'd6554;
			base_a_q <= 16'd655;
			high_q   <= 16'd50;
			crit_q   <= 16'd150;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				gsbm_pkg::CFG_WARMUP:   warmup_q <= cfg.data;
				gsbm_pkg::CFG_CALIB:    calib_q  <= cfg.data;
				gsbm_pkg::CFG_SIG_A:    sig_a_q  <= cfg.data[15:0];
				gsbm_pkg::CFG_BASE_A:   base_a_q <= cfg.data[15:0];
				gsbm_pkg::CFG_HIGH_PCT: high_q   <= cfg.data[15:0];
				gsbm_pkg::CFG_CRIT_PCT: crit_q   <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// block state
	gsbm_pkg::state_t state_q, state_n;
	gsbm_pkg::phase_t phase_q;
	logic [31:0]      pstart_q;
	logic [AVW-1:0]   sig_q, base_q;
	logic             sig_pr_q, base_pr_q;
	logic [15:0]      dev_q;
	logic [31:0]      now_q;
	logic             mpass_q;     // second multiply pass of an EMA
	logic [PW:0]      ema_acc_q;
	logic             ovalid_q;
	logic [1:0]       o_phase_q, o_level_q;
	logic [15:0]      o_dev_q;
	logic [SAMPLE_BITS-1:0] o_filt_q;

	logic accept, fault, med_busy, mul_busy, div_busy;
	logic [SAMPLE_BITS-1:0] med;
	logic [PW-1:0] prod;
	logic [NW-1:0] quo;
	logic [AVW-1:0] mul_a, sig_x;
	logic [AW-1:0]  mul_b;
	logic           mul_start, div_start, adapt;
	gsbm_pkg::unit_ctl_t med_ctl;
	logic [PW:0]    ema_sum;
	logic [AVW-1:0] ema_res;
	logic [31:0]    elapsed;
	logic [NW-1:0]  diff100;

	assign in_ch.ready = (state_q == gsbm_pkg::ST_IDLE) && !(ovalid_q && !out_ch.ready);
	assign accept      = in_ch.valid && in_ch.ready;
	assign fault = (in_ch.sample == '0) || (in_ch.sample == {SAMPLE_BITS{1'b1}});
	assign med_ctl.start = accept && !fault;
	assign med_ctl.busy  = 1'b0;
	assign elapsed = now_q - pstart_q;
	assign sig_x   = {med, {gsbm_pkg::FRAC_BITS{1'b0}}};
	assign ema_sum = ema_acc_q + {1'b0, prod} + (PW+1)'(32768);
	assign ema_res = ema_sum[gsbm_pkg::FRAC_BITS +: AVW];
	assign adapt   = ({1'b0, sig_q, 2'b00} + {3'b000, sig_q}) <
		({1'b0, base_q, 2'b00} + {2'b00, base_q, 1'b0});
	assign diff100 = NW'({sig_q - base_q, 6'b0}) + NW'({sig_q - base_q, 5'b0})
		+ NW'({sig_q - base_q, 2'b0});

	gsbm_median #(.MEDIAN_LEN(MEDIAN_LEN), .SAMPLE_BITS(SAMPLE_BITS)) u_med (
		.clk(clk), .arst_n(arst_n), .ctl_in(med_ctl), .sample(in_ch.sample),
		.busy(med_busy), .median(med)
	);

	gsbm_ser_mul #(.AW(AVW), .BW(AW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .prod(prod)
	);

	gsbm_ser_div #(.NW(NW), .DW(AVW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(diff100), .den(base_q),
		.busy(div_busy), .quo(quo)
	);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			gsbm_pkg::ST_IDLE: if (accept) state_n = fault ? gsbm_pkg::ST_OUT : gsbm_pkg::ST_MED;
			gsbm_pkg::ST_MED: begin
				if (!med_busy && !med_ctl.start) begin
					state_n = gsbm_pkg::ST_SEMA;
				end
			end
			gsbm_pkg::ST_SEMA: begin
				if (!sig_pr_q) begin
					state_n = gsbm_pkg::ST_BEMA;
				end else if (!mul_busy && mpass_q && !mul_start) begin
					state_n = gsbm_pkg::ST_BEMA;
				end
			end
			gsbm_pkg::ST_BEMA: begin
				if (phase_q != gsbm_pkg::PH_CALIB && !(phase_q == gsbm_pkg::PH_READY && adapt)) begin
					state_n = (phase_q == gsbm_pkg::PH_READY) ? gsbm_pkg::ST_DIV : gsbm_pkg::ST_OUT;
				end else if (!base_pr_q || (!mul_busy && mpass_q && !mul_start)) begin
					state_n = (phase_q == gsbm_pkg::PH_READY) ? gsbm_pkg::ST_DIV : gsbm_pkg::ST_OUT;
				end
			end
			gsbm_pkg::ST_DIV: begin
				if (base_q == '0 || sig_q <= base_q || (!div_busy && !div_start)) begin
					state_n = gsbm_pkg::ST_OUT;
				end
			end
			gsbm_pkg::ST_OUT: state_n = gsbm_pkg::ST_IDLE;
			default: state_n = gsbm_pkg::ST_IDLE;
		endcase
	end

	// unit controls
	logic started_q;
	always_comb begin
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a = sig_q;
		mul_b = AW'(17'h10000 - {1'b0, sig_a_q});
		unique case (state_q)
			gsbm_pkg::ST_SEMA: begin
				mul_start = sig_pr_q && !started_q;
				mul_a = mpass_q ? sig_x : sig_q;
				mul_b = mpass_q ? AW'(sig_a_q) : AW'(17'h10000 - {1'b0, sig_a_q});
			end
			gsbm_pkg::ST_BEMA: begin
				mul_start = base_pr_q && !started_q &&
					(phase_q == gsbm_pkg::PH_CALIB || (phase_q == gsbm_pkg::PH_READY && adapt));
				mul_a = mpass_q ? sig_q : base_q;
				mul_b = mpass_q ? AW'(base_a_q) : AW'(17'h10000 - {1'b0, base_a_q});
			end
			gsbm_pkg::ST_DIV: div_start = !started_q && base_q != '0 && sig_q > base_q;
			default: ;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= gsbm_pkg::ST_IDLE;
			phase_q   <= gsbm_pkg::PH_WARMUP;
			pstart_q  <= '0;
			sig_q     <= '0;
			base_q    <= '0;
			sig_pr_q  <= 1'b0;
			base_pr_q <= 1'b0;
			dev_q     <= '0;
			mpass_q   <= 1'b0;
			started_q <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_n != state_q) begin
				started_q <= 1'b0;
				mpass_q   <= 1'b0;
			end else if (mul_start || div_start) begin
				started_q <= 1'b1;
			end
			if (state_q == gsbm_pkg::ST_OUT) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				gsbm_pkg::ST_IDLE: if (accept) begin
					if (in_ch.restart) begin
						pstart_q <= in_ch.now_ms;
					end
					if (fault) begin
						phase_q <= gsbm_pkg::PH_FAULT;
						dev_q   <= '0;
					end else if (in_ch.restart) begin
						phase_q <= gsbm_pkg::PH_WARMUP;
					end
				end
				gsbm_pkg::ST_SEMA: begin
					if (!sig_pr_q) begin
						sig_q    <= sig_x;
						sig_pr_q <= 1'b1;
					end else if (started_q && !mul_busy) begin
						if (!mpass_q) begin
							mpass_q   <= 1'b1;
							started_q <= 1'b0;
						end else begin
							sig_q <= ema_res;
						end
					end
				end
				gsbm_pkg::ST_BEMA: begin
					if (phase_q == gsbm_pkg::PH_WARMUP && elapsed > warmup_q) begin
						phase_q  <= gsbm_pkg::PH_CALIB;
						pstart_q <= now_q;
					end
					if (phase_q == gsbm_pkg::PH_CALIB || (phase_q == gsbm_pkg::PH_READY && adapt)) begin
						if (!base_pr_q) begin
							base_q    <= sig_q;
							base_pr_q <= 1'b1;
						end else if (started_q && !mul_busy) begin
							if (!mpass_q) begin
								mpass_q   <= 1'b1;
								started_q <= 1'b0;
							end else begin
								base_q <= ema_res;
							end
						end
					end
					if (phase_q == gsbm_pkg::PH_CALIB && state_n != state_q && elapsed > calib_q) begin
						phase_q <= gsbm_pkg::PH_READY;
					end
				end
				gsbm_pkg::ST_DIV: begin
					if (base_q != '0 && sig_q <= base_q) begin
						dev_q <= '0;
					end else if (started_q && !div_busy && base_q != '0) begin
						dev_q <= (quo > NW'(gsbm_pkg::DEV_SAT)) ? gsbm_pkg::DEV_SAT : quo[15:0];
					end
				end
				default: ;
			endcase
		end
	end

	// capture item time and EMA first product
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= in_ch.now_ms;
		end
		if (started_q && !mul_busy && !mpass_q) begin
			ema_acc_q <= {1'b0, prod};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == gsbm_pkg::ST_OUT) begin
			o_phase_q <= phase_q;
			o_dev_q   <= dev_q;
			o_filt_q  <= sig_q[gsbm_pkg::FRAC_BITS +: SAMPLE_BITS];
			if (phase_q != gsbm_pkg::PH_READY) o_level_q <= gsbm_pkg::LVL_OK;
			else if (dev_q < high_q) o_level_q <= gsbm_pkg::LVL_OK;
			else if (dev_q < crit_q) o_level_q <= gsbm_pkg::LVL_HIGH;
			else o_level_q <= gsbm_pkg::LVL_CRIT;
		end
	end

	assign out_ch.valid          = ovalid_q;
	assign out_ch.phase          = o_phase_q;
	assign out_ch.deviation_pct  = o_dev_q;
	assign out_ch.level          = o_level_q;
	assign out_ch.filtered_value = o_filt_q;

	// checks
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_busy && div_busy)) else $error("multiplier and divider both busy");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == gsbm_pkg::ST_IDLE) else $error("ready outside idle");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gsbm_pkg::ST_OUT |=> ovalid_q) else $error("result not shown");
endmodule
